// ===== src/roua_pkg.sv =====
// ----------------------------------------------------------------------------
// roua_pkg
// Shared codes, field widths and control types of the range-OR update
// accumulator.
// ----------------------------------------------------------------------------
package roua_pkg;

  // Fixed widths of the request and result fields.
  localparam int unsigned LenW   = 11;
  localparam int unsigned ValueW = 32;
  localparam int unsigned IndexW = 10;

  // Array length after reset.
  localparam logic [LenW-1:0] LenReset = 11'd1024;

  // Operation codes.
  localparam logic OpUpdate = 1'b0;
  localparam logic OpRead   = 1'b1;

  // Control of the running prefix counts.
  typedef struct packed {
    logic accumulate;
    logic clear;
  } prefix_ctrl_t;

endpackage

// ===== src/roua_mem.sv =====
// ----------------------------------------------------------------------------
// roua_mem
// Difference counter store: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module roua_mem #(
  parameter int unsigned Depth = 1025,
  parameter int unsigned Width = 512,
  parameter int unsigned AddrW = 11
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ===== src/roua_prefix.sv =====
// ----------------------------------------------------------------------------
// roua_prefix
// Per-bit running counts: adds one difference row and reports which bits
// are covered at the current element.
// ----------------------------------------------------------------------------
module roua_prefix
  import roua_pkg::*;
#(
  parameter int unsigned ValueBits = 32,
  parameter int unsigned CountBits = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  prefix_ctrl_t                   ctrl_i,
  input  logic [ValueBits*CountBits-1:0] row_i,
  output logic [ValueBits-1:0]           value_o
);

  logic [ValueBits-1:0][CountBits-1:0] run_q;
  logic [ValueBits-1:0][CountBits-1:0] run_d;
  logic [ValueBits-1:0][CountBits-1:0] row;

  assign row = row_i;

  always_comb begin
    for (int j = 0; j < ValueBits; j++) begin
      run_d[j]   = run_q[j] + row[j];
      value_o[j] = (run_d[j] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else if (ctrl_i.clear) begin
      run_q <= '0;
    end else if (ctrl_i.accumulate) begin
      run_q <= run_d;
    end
  end

endmodule

// ===== src/range_or_update_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// range_or_update_accumulator_core
// Range-OR updates over an array kept as per-bit difference counters, with
// elements read back in index order through running prefix counts.
// ----------------------------------------------------------------------------
// An update request reads and writes back the row at left-1, then the row at
// right, through the single write port of the counter store; an update that
// is ignored for its range or dropped at the counter limit writes nothing and
// leaves the block idle. A read request reads one row, then adds it into the
// prefix counts and loads the output register, waiting while that register is
// stalled. After reset and after the last element of a batch has been read, a
// clearing pass writes zeros to all MAX_LENGTH+1 rows, one row per cycle,
// during which no request is taken. Configuration writes are accepted at
// any time but are meant for when the block is idle.
module range_or_update_accumulator_core
  import roua_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = 1024,
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LenW-1:0]   cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic [LenW-1:0]   left_i,
  input  logic [LenW-1:0]   right_i,
  input  logic [ValueW-1:0] mask_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ValueW-1:0] value_o,
  output logic [IndexW-1:0] index_o,
  output logic              last_o,
  output logic              overflow_o
);

  localparam int unsigned Depth = MAX_LENGTH + 1;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned PosW  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int unsigned RowW  = VALUE_BITS * COUNT_BITS;
  localparam int unsigned CntW  = COUNT_BITS - 1;
  localparam logic [AddrW-1:0] LastRow   = AddrW'(MAX_LENGTH);
  localparam logic [CntW-1:0]  UpdateCap = '1;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StUpdA,
    StUpdB,
    StRead
  } state_e;

  state_e state_q;

  logic [LenW-1:0]       array_len_q;
  logic [AddrW-1:0]      addr_a_q;
  logic [AddrW-1:0]      addr_b_q;
  logic [AddrW-1:0]      clr_addr_q;
  logic [VALUE_BITS-1:0] mask_q;
  logic [PosW-1:0]       pos_q;
  logic [CntW-1:0]       count_q;
  logic                  overflow_q;

  logic                  out_valid_q;
  logic                  out_valid_d;
  logic [ValueW-1:0]     value_q;
  logic [IndexW-1:0]     index_q;
  logic                  last_q;
  logic                  out_overflow_q;

  // Counter store interface.
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [RowW-1:0]  mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic [RowW-1:0]  mem_rdata;

  logic [VALUE_BITS-1:0][COUNT_BITS-1:0] row_rd;
  logic [VALUE_BITS-1:0][COUNT_BITS-1:0] row_inc;
  logic [VALUE_BITS-1:0][COUNT_BITS-1:0] row_dec;

  prefix_ctrl_t          prefix_ctrl;
  logic [VALUE_BITS-1:0] prefix_value;

  logic [31:0]    len_eff;
  logic           accept;
  logic           upd_valid;
  logic [LenW-1:0] left_m1;
  logic           out_free;
  logic           read_last;

  // Effective length: zero acts as one, anything above the capacity is
  // clamped to it.
  always_comb begin
    if (array_len_q == '0) begin
      len_eff = 32'd1;
    end else if (32'(array_len_q) > MAX_LENGTH) begin
      len_eff = 32'(MAX_LENGTH);
    end else begin
      len_eff = 32'(array_len_q);
    end
  end

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign left_m1    = left_i - LenW'(1);
  assign upd_valid  = (left_i != '0) && (left_i <= right_i) && (32'(right_i) <= len_eff);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign read_last  = (32'(pos_q) >= (len_eff - 32'd1));

  // The output register empties when its result is taken and refills when a
  // read completes; both can happen at the same edge.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if ((state_q == StRead) && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  assign row_rd = mem_rdata;

  always_comb begin
    for (int j = 0; j < VALUE_BITS; j++) begin
      row_inc[j] = row_rd[j] + COUNT_BITS'(mask_q[j]);
      row_dec[j] = row_rd[j] - COUNT_BITS'(mask_q[j]);
    end
  end

  // Memory port selection by state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_a_q;
    mem_wdata = row_inc;
    mem_re    = 1'b0;
    mem_raddr = addr_b_q;
    case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
        mem_wdata = '0;
      end
      StIdle: begin
        // Ignored updates may carry addresses past the store, so they do not
        // read it.
        mem_re = accept && ((operation_i == OpRead) || upd_valid);
        if (operation_i == OpRead) begin
          mem_raddr = AddrW'(pos_q);
        end else begin
          mem_raddr = AddrW'(32'(left_m1));
        end
      end
      StUpdA: begin
        // Rows left-1 and right always differ, so no forwarding is needed.
        mem_we    = 1'b1;
        mem_waddr = addr_a_q;
        mem_wdata = row_inc;
        mem_re    = 1'b1;
        mem_raddr = addr_b_q;
      end
      StUpdB: begin
        mem_we    = 1'b1;
        mem_waddr = addr_b_q;
        mem_wdata = row_dec;
      end
      StRead: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    prefix_ctrl.accumulate = (state_q == StRead) && out_free;
    prefix_ctrl.clear      = (state_q == StRead) && out_free && read_last;
  end

  roua_mem #(
    .Depth (Depth),
    .Width (RowW),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

  roua_prefix #(
    .ValueBits (VALUE_BITS),
    .CountBits (COUNT_BITS)
  ) u_prefix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (prefix_ctrl),
    .row_i   (mem_rdata),
    .value_o (prefix_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StClear;
      array_len_q    <= LenReset;
      clr_addr_q     <= '0;
      pos_q          <= '0;
      count_q        <= '0;
      overflow_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      addr_a_q       <= '0;
      addr_b_q       <= '0;
      mask_q         <= '0;
      value_q        <= '0;
      index_q        <= '0;
      last_q         <= 1'b0;
      out_overflow_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        array_len_q <= cfg_data_i;
      end
      out_valid_q <= out_valid_d;
      case (state_q)
        StClear: begin
          if (clr_addr_q == LastRow) begin
            clr_addr_q <= '0;
            state_q    <= StIdle;
          end else begin
            clr_addr_q <= clr_addr_q + AddrW'(1);
          end
        end
        StIdle: begin
          if (accept) begin
            if (operation_i == OpRead) begin
              state_q <= StRead;
            end else if (upd_valid) begin
              if (count_q == UpdateCap) begin
                overflow_q <= 1'b1;
              end else begin
                count_q  <= count_q + CntW'(1);
                addr_a_q <= AddrW'(32'(left_m1));
                addr_b_q <= AddrW'(32'(right_i));
                mask_q   <= mask_i[VALUE_BITS-1:0];
                state_q  <= StUpdA;
              end
            end
          end
        end
        StUpdA: begin
          state_q <= StUpdB;
        end
        StUpdB: begin
          state_q <= StIdle;
        end
        StRead: begin
          if (out_free) begin
            value_q        <= ValueW'(prefix_value);
            index_q        <= IndexW'(pos_q);
            last_q         <= read_last;
            out_overflow_q <= overflow_q;
            if (read_last) begin
              pos_q      <= '0;
              count_q    <= '0;
              overflow_q <= 1'b0;
              state_q    <= StClear;
            end else begin
              pos_q   <= pos_q + PosW'(1);
              state_q <= StIdle;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign index_o     = index_q;
  assign last_o      = last_q;
  assign overflow_o  = out_overflow_q;

endmodule
